// ===== src/dsti_pkg.sv =====
`timescale 1ns / 1ps

package dsti_pkg;

  // Widths fixed by the item fields
  localparam int unsigned CH_W    = 8;
  localparam int unsigned VALUE_W = 32;
  localparam int unsigned POS_W   = 12;

  // Offset saturation; also held to what the 12-bit field can carry
  localparam int unsigned OFFSET_MAX = 4095;
  localparam int unsigned POS_CAP    = (1 << POS_W) - 1;
  localparam int unsigned POS_LIMIT  = (OFFSET_MAX < POS_CAP) ? OFFSET_MAX : POS_CAP;

  // Character codes
  localparam logic [CH_W-1:0] CH_SPACE = 8'h20;
  localparam logic [CH_W-1:0] CH_MINUS = 8'h2D;
  localparam logic [CH_W-1:0] CH_ZERO  = 8'h30;
  localparam logic [CH_W-1:0] CH_NINE  = 8'h39;

  // Largest magnitude that can still take one more digit
  localparam logic [VALUE_W-1:0] MAG_LIMIT  = 32'd214748364;
  // Last digit allowed at MAG_LIMIT is below this (plus one when negative)
  localparam logic [3:0]         DIGIT_EDGE = 4'd8;

  localparam logic [VALUE_W-1:0] SAT_POS = 32'h7FFF_FFFF;
  localparam logic [VALUE_W-1:0] SAT_NEG = 32'h8000_0000;

  typedef enum logic [1:0] {
    PH_DONE   = 2'd0,
    PH_LEAD   = 2'd1,
    PH_SIGN   = 2'd2,
    PH_DIGITS = 2'd3
  } phase_e;

  typedef struct packed {
    phase_e             phase;
    logic               negative;
    logic [VALUE_W-1:0] magnitude;
    logic               overflow_seen;
    logic [POS_W-1:0]   position;
  } conv_state_t;

  typedef struct packed {
    logic [VALUE_W-1:0] value;
    logic [POS_W-1:0]   end_offset;
    logic               digits_found;
    logic               overflowed;
  } conv_result_t;

endpackage

// ===== src/dsti_step.sv =====
`timescale 1ns / 1ps

// One character of the conversion: next state and the optional result.
module dsti_step (
  input  dsti_pkg::conv_state_t  state_i,
  input  logic [7:0]             ch_i,
  input  logic                   start_req_i,
  output dsti_pkg::conv_state_t  state_o,
  output logic                   res_valid_o,
  output dsti_pkg::conv_result_t res_o
);
  import dsti_pkg::*;

  conv_state_t        cur;
  logic               is_digit;
  logic [3:0]         digit;
  logic               ovf_hit;
  logic [VALUE_W-1:0] mag_next;
  logic [POS_W-1:0]   pos_adv;
  logic [4:0]         digit_cap;

  assign is_digit  = (ch_i >= CH_ZERO) && (ch_i <= CH_NINE);
  assign digit     = ch_i[3:0];
  assign digit_cap = {1'b0, DIGIT_EDGE} + {4'd0, cur.negative};

  always_comb begin
    cur = state_i;
    if (start_req_i) begin
      cur.phase         = PH_LEAD;
      cur.negative      = 1'b0;
      cur.magnitude     = '0;
      cur.overflow_seen = 1'b0;
      cur.position      = '0;
    end
  end

  // Accumulate: x*10 as two shifts, sticky overflow freezes the magnitude
  assign ovf_hit  = !cur.overflow_seen && (cur.magnitude >= MAG_LIMIT) &&
                    ((cur.magnitude > MAG_LIMIT) || ({1'b0, digit} >= digit_cap));
  assign mag_next = (cur.magnitude << 3) + (cur.magnitude << 1) +
                    {{(VALUE_W-4){1'b0}}, digit};
  assign pos_adv  = (cur.position < POS_W'(POS_LIMIT)) ? cur.position + 1'b1
                                                       : POS_W'(POS_LIMIT);

  always_comb begin
    state_o     = cur;
    res_valid_o = 1'b0;
    res_o       = '0;
    unique case (cur.phase) inside
      PH_DONE: begin
      end
      PH_LEAD, PH_SIGN: begin
        if (cur.phase == PH_LEAD && ch_i == CH_SPACE) begin
          state_o.position = pos_adv;
        end else if (cur.phase == PH_LEAD && ch_i == CH_MINUS) begin
          state_o.negative = 1'b1;
          state_o.phase    = PH_SIGN;
          state_o.position = pos_adv;
        end else if (is_digit) begin
          state_o.phase         = PH_DIGITS;
          state_o.position      = pos_adv;
          state_o.overflow_seen = cur.overflow_seen | ovf_hit;
          if (!cur.overflow_seen && !ovf_hit) state_o.magnitude = mag_next;
        end else begin
          // no digits: all-zero result
          state_o.phase = PH_DONE;
          res_valid_o   = 1'b1;
        end
      end
      PH_DIGITS: begin
        if (is_digit) begin
          state_o.position      = pos_adv;
          state_o.overflow_seen = cur.overflow_seen | ovf_hit;
          if (!cur.overflow_seen && !ovf_hit) state_o.magnitude = mag_next;
        end else begin
          state_o.phase = PH_DONE;
          res_valid_o   = 1'b1;
          if (cur.overflow_seen) begin
            res_o.value = cur.negative ? SAT_NEG : SAT_POS;
          end else begin
            res_o.value = cur.negative ? (~cur.magnitude + 1'b1) : cur.magnitude;
          end
          res_o.end_offset   = cur.position;
          res_o.digits_found = 1'b1;
          res_o.overflowed   = cur.overflow_seen;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

// ===== src/decimal_string_to_int32.sv =====
`timescale 1ns / 1ps

// Decimal text to signed 32-bit converter, one character per request. A
// request with start_req_i set begins a new conversion at offset 0; spaces
// are skipped, one minus sign is taken, then digits, and the first character
// that cannot continue the number yields one result (saturated on overflow,
// value and offset 0 when no digits). Throughput is one character per clock
// while the result side does not stall: each character is captured in an
// input register, then a single step of digit logic (shift-add by ten,
// overflow check) updates the conversion state and loads the result
// register, so a result passes through the input register and the result
// register before it is presented. While a result waits under out_stall_i,
// one more character can be captured; after that in_stall_o rises until the
// result is taken.
module decimal_string_to_int32 (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [7:0]         ch_i,
  input  logic               start_req_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [31:0] value_o,
  output logic [11:0]        end_offset_o,
  output logic               digits_found_o,
  output logic               overflowed_o
);
  import dsti_pkg::*;

  // input register
  logic            in_vld_q, in_vld_d;
  logic [CH_W-1:0] ch_q;
  logic            start_q;

  // conversion state
  conv_state_t state_q, state_d;

  // result register
  logic         out_vld_q, out_vld_d;
  conv_result_t res_q;

  logic         in_fire;
  logic         out_free;
  logic         proc_fire;
  logic         step_res_vld;
  conv_result_t step_res;

  // The held character only moves on when the result slot can take a result
  assign out_free   = !out_vld_q || !out_stall_i;
  assign proc_fire  = in_vld_q && out_free;
  assign in_stall_o = in_vld_q && !out_free;
  assign in_fire    = in_valid_i && !in_stall_o;

  assign in_vld_d  = in_fire || (in_vld_q && !proc_fire);
  assign out_vld_d = proc_fire ? step_res_vld : (out_vld_q && out_stall_i);

  dsti_step u_step (
    .state_i     (state_q),
    .ch_i        (ch_q),
    .start_req_i (start_q),
    .state_o     (state_d),
    .res_valid_o (step_res_vld),
    .res_o       (step_res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
      state_q   <= '{phase: PH_DONE, negative: 1'b0, magnitude: '0,
                     overflow_seen: 1'b0, position: '0};
    end else begin
      in_vld_q  <= in_vld_d;
      out_vld_q <= out_vld_d;
      if (proc_fire) state_q <= state_d;
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      ch_q    <= ch_i;
      start_q <= start_req_i;
    end
    if (proc_fire && step_res_vld) res_q <= step_res;
  end

  assign out_valid_o    = out_vld_q;
  assign value_o        = signed'(res_q.value);
  assign end_offset_o   = res_q.end_offset;
  assign digits_found_o = res_q.digits_found;
  assign overflowed_o   = res_q.overflowed;

endmodule

// ===== dv/decimal_string_to_int32_test.sv =====
`timescale 1ns / 1ps

module decimal_string_to_int32_test;
  import dsti_pkg::*;

  // Stop when nothing has moved on either channel for this many cycles
  localparam int QUIET_LIMIT = 5000;
  // Result passes through the input and result registers; leave some slack
  localparam int TAIL_CYCLES = 8;
  localparam int RANDOM_REQUESTS = 850;

  // Own copies of the numeric edges, kept apart from the RTL constants
  localparam logic [31:0] TENTH_OF_MAX = 32'd214748364;
  localparam logic [31:0] INT_MAX_BITS = 32'h7FFF_FFFF;
  localparam logic [31:0] INT_MIN_BITS = 32'h8000_0000;
  localparam conv_result_t NO_DIGITS   = '0;

  // One directed request; typed rows carry a hand-written expected result
  typedef struct {
    logic [CH_W-1:0] ch;
    logic            start;
    bit              typed;
    conv_result_t    res;
  } dir_row_t;

  logic               clk_i;
  logic               rst_ni      = 1'b0;
  logic               in_valid_i  = 1'b0;
  logic               in_stall_o;
  logic [CH_W-1:0]    ch_i        = '0;
  logic               start_req_i = 1'b0;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  logic signed [31:0] value_o;
  logic [11:0]        end_offset_o;
  logic               digits_found_o;
  logic               overflowed_o;

  // Shadow of the converter state, advanced once per accepted request
  conv_state_t  shadow = '0;
  conv_result_t pending_results[$];

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int requests_counted = 0;
  int results_checked = 0;
  int overflow_results = 0;
  int empty_results = 0;
  int errors = 0;
  int quiet_cycles = 0;

  decimal_string_to_int32 i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .ch_i           (ch_i),
    .start_req_i    (start_req_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .value_o        (value_o),
    .end_offset_o   (end_offset_o),
    .digits_found_o (digits_found_o),
    .overflowed_o   (overflowed_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  // Offset counter saturates at the parameter cap (held to the 12-bit field)
  function automatic void bump_offset();
    if (shadow.position < POS_LIMIT) begin
      shadow.position = shadow.position + 1'b1;
    end
  endfunction

  // Accumulate one digit; once past the signed range the magnitude freezes
  // and the overflow flag sticks until the next start.
  function automatic void take_digit(input logic [3:0] d);
    if (shadow.overflow_seen) begin
      return;
    end
    if (shadow.magnitude >= TENTH_OF_MAX &&
        (shadow.magnitude > TENTH_OF_MAX || d >= 4'd8 + shadow.negative)) begin
      shadow.overflow_seen = 1'b1;
    end else begin
      shadow.magnitude = shadow.magnitude * 32'd10 + d;
    end
  endfunction

  // Consume one character; returns 1 when it terminates a conversion
  function automatic bit convert_char(input logic [CH_W-1:0] c, input logic st,
                                      output conv_result_t res);
    logic is_digit;
    is_digit = (c >= CH_ZERO) && (c <= CH_NINE);
    res = NO_DIGITS;
    if (st) begin
      // a start drops whatever conversion was running, without a result
      shadow.phase         = PH_LEAD;
      shadow.negative      = 1'b0;
      shadow.magnitude     = '0;
      shadow.overflow_seen = 1'b0;
      shadow.position      = '0;
    end
    if (shadow.phase == PH_DONE) begin
      return 1'b0;
    end
    if (shadow.phase == PH_LEAD && c == CH_SPACE) begin
      bump_offset();
      return 1'b0;
    end
    if (shadow.phase == PH_LEAD && c == CH_MINUS) begin
      shadow.negative = 1'b1;
      shadow.phase    = PH_SIGN;
      bump_offset();
      return 1'b0;
    end
    if (shadow.phase != PH_DIGITS) begin
      // still before the first digit: anything else means no number
      if (!is_digit) begin
        shadow.phase = PH_DONE;
        return 1'b1;
      end
      shadow.phase = PH_DIGITS;
      take_digit(4'(c - CH_ZERO));
      bump_offset();
      return 1'b0;
    end
    if (is_digit) begin
      take_digit(4'(c - CH_ZERO));
      bump_offset();
      return 1'b0;
    end
    if (shadow.overflow_seen) begin
      res.value = shadow.negative ? INT_MIN_BITS : INT_MAX_BITS;
    end else begin
      res.value = shadow.negative ? (32'd0 - shadow.magnitude) : shadow.magnitude;
    end
    res.end_offset   = shadow.position;
    res.digits_found = 1'b1;
    res.overflowed   = shadow.overflow_seen;
    shadow.phase     = PH_DONE;
    return 1'b1;
  endfunction

  function automatic logic [CH_W-1:0] non_digit_char();
    logic [CH_W-1:0] c;
    do begin
      c = CH_W'($urandom_range(0, 255));
    end while (c >= CH_ZERO && c <= CH_NINE);
    return c;
  endfunction

  // ---------------------------------------------------------------------------
  // Request side
  // ---------------------------------------------------------------------------

  // Drive one request and hold it until accepted. A typed row pushes its
  // hand-written result in place of the predicted one.
  task automatic drive_char(input logic [CH_W-1:0] c, input logic st,
                            input bit typed, input conv_result_t typed_res);
    conv_result_t res;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    ch_i        <= c;
    start_req_i <= st;
    @(posedge clk_i);
    while (in_stall_o) begin
      @(posedge clk_i);
    end
    // requests that land while idle without a start are simply dropped
    if (st || shadow.phase != PH_DONE) begin
      requests_counted++;
    end
    if (convert_char(c, st, res)) begin
      pending_results.push_back(typed ? typed_res : res);
    end
  endtask

  // Hold off new requests until every outstanding result is back
  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_results.size() != 0) begin
      @(posedge clk_i);
    end
  endtask

  // Random traffic: mostly well-formed numbers with random content, plus
  // digitless texts and raw noise with stray starts.
  task automatic run_phase(input int send_pct, input int recv_pct, input int target);
    logic [CH_W-1:0] text[$];
    longint unsigned mag;
    string           digs;
    int              kind;
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    while (requests_counted < target) begin
      text.delete();
      kind = $urandom_range(0, 9);
      if (kind <= 6) begin
        repeat (($urandom_range(0, 2) == 0) ? $urandom_range(1, 3) : 0) begin
          text.push_back(CH_SPACE);
        end
        if ($urandom_range(0, 1) != 0) begin
          text.push_back(CH_MINUS);
        end
        if ($urandom_range(0, 5) == 0) begin
          repeat ($urandom_range(1, 12)) text.push_back(CH_ZERO);
        end
        case ($urandom_range(0, 6))
          0: mag = 64'($urandom_range(0, 9));
          1: mag = 64'($urandom_range(10, 99999));
          2: mag = 64'($urandom);
          // straddles both signed limits
          3: mag = 64'd2147483640 + $urandom_range(0, 15);
          // tenth above the limit, so the last digit overflows regardless
          4: mag = 64'd2147483650 + $urandom_range(0, 49);
          5: mag = 64'd21474836400 + $urandom_range(0, 99);
          // up to 20 digits: several digits arrive after overflow
          default: mag = {$urandom, $urandom};
        endcase
        digs = $sformatf("%0d", mag);
        foreach (digs[i]) text.push_back(digs[i]);
        // sometimes no terminator: trailing noise may end it, else the next start abandons it
        if ($urandom_range(0, 7) != 0) begin
          text.push_back(non_digit_char());
        end
      end else if (kind == 7 || kind == 8) begin
        repeat ($urandom_range(0, 2)) text.push_back(CH_SPACE);
        if ($urandom_range(0, 1) != 0) begin
          text.push_back(CH_MINUS);
        end
        text.push_back(non_digit_char());
      end
      if (kind <= 8) begin
        foreach (text[i]) drive_char(text[i], i == 0, 1'b0, NO_DIGITS);
        repeat ($urandom_range(0, 2)) begin
          drive_char(CH_W'($urandom_range(0, 255)), 1'b0, 1'b0, NO_DIGITS);
        end
      end else begin
        repeat ($urandom_range(1, 6)) begin
          drive_char(CH_W'($urandom_range(0, 255)), $urandom_range(0, 4) == 0, 1'b0,
                     NO_DIGITS);
        end
      end
      if ($urandom_range(0, 49) == 0) begin
        drain();
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Result side
  // ---------------------------------------------------------------------------

  always @(posedge clk_i) begin
    out_stall_i <= ($urandom_range(0, 99) < recv_idle_pct);
  end

  task automatic report_field(input string field, input longint want, input longint got);
    errors++;
    $display("%0t: %s mismatch: expected %0d, actual %0d", $time, field, want, got);
  endtask

  always @(posedge clk_i) begin : check_results
    conv_result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_results.size() == 0) begin
        errors++;
        $display("%0t: unexpected result: expected none, actual value %0d offset %0d",
                 $time, value_o, end_offset_o);
      end else begin
        want = pending_results.pop_front();
        results_checked++;
        if (want.overflowed) begin
          overflow_results++;
        end
        if (!want.digits_found) begin
          empty_results++;
        end
        if (value_o !== want.value) begin
          report_field("value", longint'($signed(want.value)), longint'(value_o));
        end
        if (end_offset_o !== want.end_offset) begin
          report_field("end_offset", longint'(want.end_offset), longint'(end_offset_o));
        end
        if (digits_found_o !== want.digits_found) begin
          report_field("digits_found", longint'(want.digits_found),
                       longint'(digits_found_o));
        end
        if (overflowed_o !== want.overflowed) begin
          report_field("overflowed", longint'(want.overflowed), longint'(overflowed_o));
        end
      end
    end
  end

  // Watchdog: any accepted request on either side resets the count
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    wait (quiet_cycles >= QUIET_LIMIT);
    $display("%0t: no progress for %0d cycles", $time, QUIET_LIMIT);
    $display("decimal_string_to_int32_test: done, errors");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------

  initial begin
    dir_row_t directed[$];
    string    digs;

    // ignored while idle, then a digitless start on the lowest byte
    directed.push_back(dir_row_t'{8'h5A, 1'b0, 1'b0, NO_DIGITS});
    directed.push_back(dir_row_t'{8'h00, 1'b1, 1'b1, NO_DIGITS});
    // repeated minus, then a space right after the minus
    directed.push_back(dir_row_t'{CH_MINUS, 1'b1, 1'b0, NO_DIGITS});
    directed.push_back(dir_row_t'{CH_MINUS, 1'b0, 1'b1, NO_DIGITS});
    directed.push_back(dir_row_t'{CH_MINUS, 1'b1, 1'b0, NO_DIGITS});
    directed.push_back(dir_row_t'{CH_SPACE, 1'b0, 1'b1, NO_DIGITS});
    // "99" cut short by a new start, which ends on the highest byte
    directed.push_back(dir_row_t'{8'h39, 1'b1, 1'b0, NO_DIGITS});
    directed.push_back(dir_row_t'{8'h39, 1'b0, 1'b0, NO_DIGITS});
    directed.push_back(dir_row_t'{8'h31, 1'b1, 1'b0, NO_DIGITS});
    directed.push_back(dir_row_t'{8'hFF, 1'b0, 1'b0, NO_DIGITS});
    // one past the negative limit: saturates low, terminator just below '0'
    directed.push_back(dir_row_t'{CH_MINUS, 1'b1, 1'b0, NO_DIGITS});
    digs = "2147483649";
    foreach (digs[i]) directed.push_back(dir_row_t'{digs[i], 1'b0, 1'b0, NO_DIGITS});
    directed.push_back(dir_row_t'{8'h2F, 1'b0, 1'b1,
                                  conv_result_t'{INT_MIN_BITS, 12'd11, 1'b1, 1'b1}});
    // just above '9' while idle, then as a terminator
    directed.push_back(dir_row_t'{8'h3A, 1'b0, 1'b0, NO_DIGITS});
    directed.push_back(dir_row_t'{8'h37, 1'b1, 1'b0, NO_DIGITS});
    directed.push_back(dir_row_t'{8'h3A, 1'b0, 1'b0, NO_DIGITS});

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_idle_pct = 33;
    recv_idle_pct = 82;
    foreach (directed[i]) begin
      drive_char(directed[i].ch, directed[i].start, directed[i].typed, directed[i].res);
    end

    // three idle mixes, with a full drain between them
    run_phase(33, 82, requests_counted + RANDOM_REQUESTS / 3);
    drain();
    run_phase(82, 33, requests_counted + RANDOM_REQUESTS / 3);
    drain();
    run_phase(0, 0, requests_counted + RANDOM_REQUESTS / 3);

    drain();
    repeat (TAIL_CYCLES) @(posedge clk_i);

    $display("covered %0d characters: directed edge cases, then three stall mixes",
             requests_counted);
    $display("checked %0d results: %0d saturated on overflow, %0d without digits",
             results_checked, overflow_results, empty_results);
    if (errors == 0) begin
      $display("decimal_string_to_int32_test: done, clean");
    end else begin
      $display("decimal_string_to_int32_test: done, errors");
    end
    $finish;
  end

endmodule
